// ===== rtl/b32sc_pkg.sv =====
// b32sc_pkg: types, constants and alphabet functions for the base32 stream codec
// no dependencies; imported by every module of the codec
`default_nettype none

package b32sc_pkg;

  localparam int MAX_RES = 3;
  localparam int CFG_AW  = 3;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // word index of the direction register
  localparam logic IDX_DIRECTION = 1'b0;

  typedef struct packed {
    logic [7:0] data_in;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       data_valid;
    logic       out_last;
    logic       bad_symbol;
  } out_item_t;

  // results caused by one input item, res[0] leaves first
  typedef struct packed {
    out_item_t [MAX_RES-1:0] res;
    logic [1:0]              num;
  } q_entry_t;

  typedef struct packed {
    logic dir;
    logic clr;
  } front_ctl_t;

  function automatic logic [7:0] sym_char(input logic [4:0] v);
    logic [7:0] c;
    case (v)
      5'd0:  c = "A";
      5'd1:  c = "B";
      5'd2:  c = "C";
      5'd3:  c = "D";
      5'd4:  c = "E";
      5'd5:  c = "F";
      5'd6:  c = "G";
      5'd7:  c = "H";
      5'd8:  c = "J";
      5'd9:  c = "K";
      5'd10: c = "M";
      5'd11: c = "N";
      5'd12: c = "P";
      5'd13: c = "Q";
      5'd14: c = "R";
      5'd15: c = "S";
      5'd16: c = "T";
      5'd17: c = "V";
      5'd18: c = "W";
      5'd19: c = "X";
      5'd20: c = "Y";
      5'd21: c = "Z";
      5'd22: c = "2";
      5'd23: c = "3";
      5'd24: c = "4";
      5'd25: c = "5";
      5'd26: c = "6";
      5'd27: c = "7";
      5'd28: c = "8";
      5'd29: c = "9";
      5'd30: c = "0";
      5'd31: c = "1";
      default: c = "A";
    endcase
    return c;
  endfunction

  // returns {hit, value}
  function automatic logic [5:0] sym_lookup(input logic [7:0] ch);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (sym_char(5'(i)) == ch) begin
        r = {1'b1, 5'(i)};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/b32sc_queue.sv =====
// b32sc_queue: short fifo of result groups between front and back
// depends on b32sc_pkg for the entry type
`default_nettype none

module b32sc_queue
  import b32sc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  q_entry_t      wdata,
  input  wire logic     pop,
  output q_entry_t      head,
  output logic          full,
  output logic          empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == DEPTH_C);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b32sc_front.sv =====
// b32sc_front: accepts items, keeps the bit buffer and builds each item's result group
// depends on b32sc_pkg for item types and the alphabet functions
`default_nettype none

module b32sc_front
  import b32sc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  front_ctl_t ctl,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  input  wire logic  q_full,
  output logic       push,
  output q_entry_t   entry
);

  logic [11:0] bit_buffer_r, bit_buffer_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic        discarding_r, discarding_nxt;

  logic        accept;
  logic [11:0] ebuf, dbuf;
  logic [3:0]  ecnt, dcnt, rem;
  logic [5:0]  lk;
  logic [1:0]  n;
  q_entry_t    ent;
  out_item_t   marker;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (ent.num != '0);
  assign entry    = ent;

  always_comb begin
    bit_buffer_nxt = bit_buffer_r;
    bit_count_nxt  = bit_count_r;
    discarding_nxt = discarding_r;
    ent    = '0;
    n      = '0;
    rem    = '0;
    dcnt   = '0;
    dbuf   = '0;
    marker = '{data_out: 8'd0, data_valid: 1'b0, out_last: 1'b1, bad_symbol: 1'b0};
    ebuf   = {bit_buffer_r[3:0], in_data.data_in};
    ecnt   = bit_count_r + 4'd8;
    lk     = sym_lookup(in_data.data_in);

    if (ctl.dir == DIR_ENCODE) begin
      // first group always completes (8 to 12 bits pending)
      ent.res[0] = '{data_out: sym_char(5'(ebuf >> (ecnt - 4'd5))), data_valid: 1'b1,
                     out_last: 1'b0, bad_symbol: 1'b0};
      if (ecnt >= 4'd10) begin
        rem = ecnt - 4'd10;
        ent.res[1] = '{data_out: sym_char(5'(ebuf >> rem)), data_valid: 1'b1,
                       out_last: 1'b0, bad_symbol: 1'b0};
        n = 2'd2;
      end else begin
        rem = ecnt - 4'd5;
        n = 2'd1;
      end
      if (in_data.in_last) begin
        // flush leftover bits, zero-filled on the right
        if (rem != '0) begin
          ent.res[n] = '{data_out: sym_char(5'(ebuf[4:0] << (3'd5 - rem[2:0]))),
                         data_valid: 1'b1, out_last: 1'b0, bad_symbol: 1'b0};
          n = n + 2'd1;
        end
        ent.res[n - 2'd1].out_last = 1'b1;
        bit_buffer_nxt = '0;
        bit_count_nxt  = '0;
        discarding_nxt = 1'b0;
      end else begin
        bit_buffer_nxt = ebuf;
        bit_count_nxt  = rem;
      end
    end else if (discarding_r) begin
      if (in_data.in_last) begin
        ent.res[0] = marker;
        n = 2'd1;
        bit_buffer_nxt = '0;
        bit_count_nxt  = '0;
        discarding_nxt = 1'b0;
      end
    end else if (!lk[5]) begin
      ent.res[0] = '{data_out: 8'd0, data_valid: 1'b0, out_last: in_data.in_last,
                     bad_symbol: 1'b1};
      n = 2'd1;
      if (in_data.in_last) begin
        bit_buffer_nxt = '0;
        bit_count_nxt  = '0;
        discarding_nxt = 1'b0;
      end else begin
        discarding_nxt = 1'b1;
      end
    end else begin
      dbuf = {bit_buffer_r[6:0], lk[4:0]};
      dcnt = bit_count_r + 4'd5;
      if (dcnt >= 4'd8) begin
        dcnt = dcnt - 4'd8;
        ent.res[0] = '{data_out: 8'(dbuf >> dcnt), data_valid: 1'b1,
                       out_last: in_data.in_last, bad_symbol: 1'b0};
        n = 2'd1;
      end
      if (in_data.in_last) begin
        if (n == '0) begin
          ent.res[0] = marker;
          n = 2'd1;
        end
        bit_buffer_nxt = '0;
        bit_count_nxt  = '0;
        discarding_nxt = 1'b0;
      end else begin
        bit_buffer_nxt = dbuf;
        bit_count_nxt  = dcnt;
      end
    end
    ent.num = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      bit_buffer_r <= '0;
      bit_count_r  <= '0;
      discarding_r <= 1'b0;
    end else if (accept) begin
      bit_buffer_r <= bit_buffer_nxt;
      bit_count_r  <= bit_count_nxt;
      discarding_r <= discarding_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b32sc_back.sv =====
// b32sc_back: walks the head result group and sends one result per cycle while the receiver is ready
// depends on b32sc_pkg for the entry and result types
`default_nettype none

module b32sc_back
  import b32sc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  q_entry_t  head,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  logic [1:0] sel_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  logic       load;
  logic       last_sel;

  assign load      = !q_empty && (!out_valid_r || out_ready);
  assign last_sel  = (sel_r == head.num - 2'd1);
  assign pop       = load && last_sel;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        sel_r       <= last_sel ? 2'd0 : sel_r + 2'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= head.res[sel_r];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/base32_stream_codec.sv =====
// base32_stream_codec: top level, apb register, front, queue and back
// depends on b32sc_pkg, b32sc_front, b32sc_queue and b32sc_back
`default_nettype none

// streaming base32 codec, fixed 32-symbol alphabet, msb first, no padding.
// direction (register 0, byte address 0) picks encode (0) or decode (1); any
// write to it aborts the stream in progress, so write it only between streams.
// every request gives from zero to three results: encode emits one or two
// characters per byte plus a flush character on a last byte with bits left,
// decode emits at most one byte per character, an error result with
// bad_symbol for a character outside the alphabet, and a marker (data_valid 0,
// out_last 1) on a last request that yields no data. after an error the rest
// of the stream up to its last request is dropped and already sent bytes must
// be rejected downstream. timing: the front takes one request per cycle while
// the queue has room; the back sends one result per cycle from the head group
// while the receiver is ready, so throughput is set by the result count. the
// first result of a request is registered in the queue entry and then in the
// output register. no clearing pass after reset.

module base32_stream_codec
  import b32sc_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  // apb configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic       dir_r;
  logic       dir_wr;
  front_ctl_t ctl;
  logic       q_push, q_pop, q_full, q_empty;
  q_entry_t   q_wdata, q_head;

  // register file: one word, decoded on the word index
  assign pready = 1'b1;
  assign dir_wr = psel && penable && pwrite && pready && (paddr[2] == IDX_DIRECTION);
  assign prdata = (paddr[2] == IDX_DIRECTION) ? {31'd0, dir_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_ENCODE;
    end else if (dir_wr) begin
      dir_r <= pwdata[0];
    end
  end

  // the write also clears the stream state in the front
  assign ctl = '{dir: dir_r, clr: dir_wr};

  // front: classify each request and build its result group
  b32sc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (q_push),
    .entry    (q_wdata)
  );

  // queue of result groups, decouples request and result sides
  b32sc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: serialize the head group into the output register
  b32sc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a result without data is always an error or an end marker
  a_nodata_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.data_valid |-> out_data.out_last || out_data.bad_symbol)
    else $error("result without data is neither error nor end marker");

  // a result without data carries a zero data field
  a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.data_valid |-> out_data.data_out == 8'd0)
    else $error("result without data has nonzero data_out");

  // queued groups always hold one to three results
  a_group_size: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> q_head.num != 2'd0)
    else $error("queued result group has zero results");

  // a pushed group is never empty
  a_push_size: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_wdata.num != 2'd0)
    else $error("empty result group pushed");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench for base32_stream_codec (encode and decode)
// depends on b32sc_pkg and the codec rtl; a scoreboard class predicts results

import b32sc_pkg::*;

// tracks the codec state, predicts the results of every accepted request and
// checks each result against the oldest one still owed
class codec_scoreboard;
  byte unsigned alphabet [32];
  logic         dir;
  logic [11:0]  bit_buf;
  logic [3:0]   bit_cnt;
  logic         dropping;
  out_item_t    owed_results[$];
  int           errors;

  function new();
    string s;
    s = "ABCDEFGHJKMNPQRSTVWXYZ2345678901";
    for (int i = 0; i < 32; i++) alphabet[i] = s[i];
    dir    = DIR_ENCODE;
    errors = 0;
    clear_stream();
  endfunction

  function void clear_stream();
    bit_buf  = '0;
    bit_cnt  = '0;
    dropping = 1'b0;
  endfunction

  function out_item_t result_of(logic [7:0] d, logic v, logic l, logic b);
    out_item_t r;
    r.data_out   = d;
    r.data_valid = v;
    r.out_last   = l;
    r.bad_symbol = b;
    return r;
  endfunction

  function void note_request(in_item_t it);
    out_item_t  made[$];
    logic       found;
    logic [4:0] val;
    if (dir == DIR_ENCODE) begin
      bit_buf = {bit_buf[3:0], it.data_in};
      bit_cnt = bit_cnt + 4'd8;
      while (bit_cnt >= 5) begin
        bit_cnt = bit_cnt - 4'd5;
        made = {made, result_of(alphabet[5'(bit_buf >> bit_cnt)], 1'b1, 1'b0, 1'b0)};
      end
      if (it.in_last) begin
        // flush the leftover bits, zero filled on the right
        if (bit_cnt != 0)
          made = {made, result_of(alphabet[5'(bit_buf << (5 - bit_cnt))],
                                  1'b1, 1'b0, 1'b0)};
        made[made.size()-1].out_last = 1'b1;
        clear_stream();
      end
    end else if (dropping) begin
      if (it.in_last) begin
        made = {made, result_of(8'h00, 1'b0, 1'b1, 1'b0)};
        clear_stream();
      end
    end else begin
      found = 1'b0;
      val   = '0;
      for (int i = 0; i < 32; i++) begin
        if (alphabet[i] == it.data_in) begin
          found = 1'b1;
          val   = 5'(i);
        end
      end
      if (!found) begin
        made = {made, result_of(8'h00, 1'b0, it.in_last, 1'b1)};
        if (it.in_last) clear_stream();
        else dropping = 1'b1;
      end else begin
        bit_buf = {bit_buf[6:0], val};
        bit_cnt = bit_cnt + 4'd5;
        if (bit_cnt >= 8) begin
          bit_cnt = bit_cnt - 4'd8;
          made = {made, result_of(8'(bit_buf >> bit_cnt), 1'b1, it.in_last, 1'b0)};
        end
        if (it.in_last) begin
          if (made.size() == 0) made = {made, result_of(8'h00, 1'b0, 1'b1, 1'b0)};
          clear_stream();
        end
      end
    end
    owed_results = {owed_results, made};
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (owed_results.size() == 0) begin
      $error("unexpected result: data_out %0h valid %0b last %0b bad %0b",
             got.data_out, got.data_valid, got.out_last, got.bad_symbol);
      errors++;
      return;
    end
    want = owed_results.pop_front();
    if (got.data_out !== want.data_out) begin
      $error("data_out: expected %0h, got %0h", want.data_out, got.data_out);
      errors++;
    end
    if (got.data_valid !== want.data_valid) begin
      $error("data_valid: expected %0b, got %0b", want.data_valid, got.data_valid);
      errors++;
    end
    if (got.out_last !== want.out_last) begin
      $error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
      errors++;
    end
    if (got.bad_symbol !== want.bad_symbol) begin
      $error("bad_symbol: expected %0b, got %0b", want.bad_symbol, got.bad_symbol);
      errors++;
    end
  endfunction
endclass

module tb_top;

  // byte address of the direction register, and one that maps to no register
  localparam logic [CFG_AW-1:0] DIR_ADDR   = CFG_AW'(4 * IDX_DIRECTION);
  localparam logic [CFG_AW-1:0] SPARE_ADDR = CFG_AW'(4);

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // idle percentages of the request sender and the result receiver
  int send_gap_pct;
  int stall_pct;

  codec_scoreboard codec_sb;

  base32_stream_codec u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // receiver: ready drops at random in stalling phases
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // both handshakes are sampled here, the request first, so a prediction is
  // always in place before any result it causes can show up
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) codec_sb.note_request(in_data);
      if (out_valid && out_ready) codec_sb.check_result(out_data);
    end
  end

  // one apb transfer; the leading idle cycle keeps back-to-back calls from
  // lowering and raising psel in the same step
  task automatic apb_xfer(input logic wr, input logic [CFG_AW-1:0] addr,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write direction, mirror it in the scoreboard (a write also aborts the
  // stream in progress) and read it back
  task automatic set_direction(input logic d);
    logic [31:0] rd;
    apb_xfer(1'b1, DIR_ADDR, 32'(d), rd);
    codec_sb.dir = d;
    codec_sb.clear_stream();
    apb_xfer(1'b0, DIR_ADDR, 32'h0, rd);
    if (rd !== 32'(d)) begin
      $error("direction readback: expected %0h, got %0h", 32'(d), rd);
      codec_sb.errors++;
    end
  endtask

  // one request; valid stays high straight into the next one unless a gap
  // is drawn
  task automatic send_item(input logic [7:0] d, input logic last);
    in_item_t it;
    it.data_in = d;
    it.in_last = last;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending, wait until every owed result is in, then let the clock idle on
  // so the pipe is surely empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (codec_sb.owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [31:0] rd;
    logic [7:0]  d;
    int          left;
    int          mode;
    codec_sb = new();
    send_gap_pct = 0;
    stall_pct    = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed: encode ----
    set_direction(DIR_ENCODE);
    // single zero byte: one character plus a three-bit flush
    send_item(8'h00, 1'b1);
    // five bytes fill exactly eight characters, so no flush
    repeat (4) send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b1);
    // two bytes leave one bit to flush
    send_item(8'ha5, 1'b0);
    send_item(8'h5a, 1'b1);
    settle();

    // ---- directed: decode ----
    set_direction(DIR_DECODE);
    // lone symbol completes no byte: marker only
    send_item("A", 1'b1);
    // highest symbol value, ten bits give one byte on the last request
    send_item("1", 1'b0);
    send_item("1", 1'b1);
    // valid symbol, bad symbol mid-stream, then a dropped symbol and a dropped last
    send_item("B", 1'b0);
    send_item(8'h00, 1'b0);
    send_item("C", 1'b0);
    send_item(8'hff, 1'b1);
    // bad symbol on the last request itself (lower case is not in the set)
    send_item("Z", 1'b0);
    send_item("a", 1'b1);
    // unfinished stream: seven bits left pending
    send_item("H", 1'b0);
    send_item("J", 1'b0);
    send_item("K", 1'b0);
    settle();
    // write to an unmapped address must not touch the pending bits
    apb_xfer(1'b1, SPARE_ADDR, 32'h0, rd);
    send_item("M", 1'b0);
    settle();
    // rewriting the same direction aborts the stream, so this is a marker
    set_direction(DIR_DECODE);
    send_item("N", 1'b1);
    settle();

    // ---- random phases: each direction under each idling mode ----
    for (int ph = 0; ph < 8; ph++) begin
      mode = ph / 2;
      send_gap_pct = (mode == 1) ? 47 : (mode == 3) ? 10 : 0;
      stall_pct    = (mode == 2) ? 47 : (mode == 3) ? 10 : 0;
      set_direction((ph % 2 == 1) ? DIR_DECODE : DIR_ENCODE);
      left = 0;
      for (int k = 0; k < 31; k++) begin
        // mostly short streams, now and then a long one
        if (left == 0)
          left = ($urandom_range(7) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
        left--;
        // decode gets mostly valid symbols so streams run deep
        if (ph % 2 == 1 && $urandom_range(11) != 0)
          d = codec_sb.alphabet[$urandom_range(31)];
        else
          d = 8'($urandom_range(255));
        send_item(d, left == 0);
      end
      // a stream cut off here is aborted by the next direction write
      settle();
    end

    repeat (20) @(posedge clk);
    if (codec_sb.errors == 0 && codec_sb.owed_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/b32sc_pkg.sv
rtl/b32sc_queue.sv
rtl/b32sc_front.sv
rtl/b32sc_back.sv
rtl/base32_stream_codec.sv
test/tb_top.sv
